// File: rtl/sis_pkg.sv
package sis_pkg;

  localparam int KEY_W      = 32;
  localparam int TAG_W      = 16;
  localparam int POS_W      = 6;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  typedef struct packed {
    logic              vld;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic [POS_W-1:0]  pos;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shl;
    logic up;
  } ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_FEED,
    ST_DRAIN,
    ST_OUT
  } state_t;

endpackage

// File: rtl/sis_cell.sv
module sis_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  sis_pkg::ctl_t   ctl,
  input  sis_pkg::entry_t in_ent,
  input  sis_pkg::entry_t right_ent,
  output sis_pkg::entry_t held,
  output sis_pkg::entry_t pass
);

  sis_pkg::entry_t held_r, held_nxt;
  sis_pkg::entry_t pass_r, pass_nxt;
  logic            stays;

  // on equal keys the earlier arrival keeps its place
  assign stays = (held_r.key == in_ent.key) ? (held_r.pos < in_ent.pos)
               : ctl.up ? ($signed(held_r.key) < $signed(in_ent.key))
                        : ($signed(held_r.key) > $signed(in_ent.key));

  always_comb begin
    held_nxt     = held_r;
    pass_nxt     = in_ent;
    pass_nxt.vld = 1'b0;
    if (ctl.shl) begin
      held_nxt = right_ent;
    end else if (ctl.ins && in_ent.vld) begin
      if (!held_r.vld) begin
        held_nxt = in_ent;
      end else if (!stays) begin
        held_nxt = in_ent;
        pass_nxt = held_r;
      end else begin
        pass_nxt = in_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r.vld <= 1'b0;
      pass_r.vld <= 1'b0;
    end else begin
      held_r <= held_nxt;
      pass_r <= pass_nxt;
    end
  end

  assign held = held_r;
  assign pass = pass_r;

endmodule

// File: rtl/sis_chain.sv
module sis_chain #(
  parameter int DEPTH = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sis_pkg::ctl_t   ctl,
  input  sis_pkg::entry_t feed,
  output sis_pkg::entry_t head
);

  sis_pkg::entry_t held_a [DEPTH];
  sis_pkg::entry_t pass_a [DEPTH+1];
  sis_pkg::entry_t right_a [DEPTH];

  assign pass_a[0] = feed;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_end
      assign right_a[i] = '0;
    end else begin : g_mid
      assign right_a[i] = held_a[i+1];
    end

    sis_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .in_ent    (pass_a[i]),
      .right_ent (right_a[i]),
      .held      (held_a[i]),
      .pass      (pass_a[i+1])
    );
  end

  assign head = held_a[0];

endmodule

// File: rtl/stable_insertion_sort.sv
// stable insertion sort of signed 32-bit keys, each with a 16-bit tag
// input channel in_*: one item per cycle while in_tready is high; in_tlast
// closes the run. items beyond DEPTH are dropped and flag overflow
// result channel out_*: one result per stored item in sorted order, with
// origin position, overflow flag and out_tlast on the final result
// cfg_we/cfg_wdata: direction bit, 1 ascending, 0 descending; the value
// in force when the closing item is taken decides the order
// after the closing item of a run, the load buffer is read into the cell
// row in arrival order, the row then settles in the drain state, and the
// first result is taken from the head of the row into the output register
// results then leave at one per cycle; the cell row shifts only when the
// output register is free or taken, so a stalled receiver simply holds it
// in_tready stays low from the closing item until the final result has
// entered the output register; loading runs one item per cycle
// reset empties the row, clears fill count and overflow and sets ascending
module stable_insertion_sort #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sis_pkg::IN_DATA_W-1:0]     in_tdata,   // key, tag
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sis_pkg::OUT_DATA_W-1:0]    out_tdata,  // out_key, out_tag, origin_pos, overflow
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic                              cfg_wdata
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  sis_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   run_n_r, run_n_nxt;
  logic            ovf_r, ovf_nxt;
  logic            run_ovf_r, run_ovf_nxt;
  logic            run_up_r, run_up_nxt;
  logic            asc_r;

  logic [sis_pkg::IN_DATA_W-1:0] store_mem [DEPTH];
  logic [sis_pkg::KEY_W-1:0]     feed_key_r;
  logic [sis_pkg::TAG_W-1:0]     feed_tag_r;
  logic [AW-1:0]                 feed_pos_r;
  logic                          feed_vld_r;

  logic                           out_vld_r;
  logic                           out_last_r;
  logic [sis_pkg::OUT_DATA_W-1:0] out_data_r;

  logic            in_acc;
  logic            full;
  logic            rd_en;
  logic            take;
  logic            run_done;
  sis_pkg::ctl_t   ctl;
  sis_pkg::entry_t feed;
  sis_pkg::entry_t head;

  assign in_tready = (state_r == sis_pkg::ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (fill_r == CW'(DEPTH));
  assign rd_en     = (state_r == sis_pkg::ST_FEED);
  assign take      = (state_r == sis_pkg::ST_OUT) && (!out_vld_r || out_tready);
  assign run_done  = (cnt_r == run_n_r - CW'(1));

  assign ctl.ins = (state_r == sis_pkg::ST_FEED) || (state_r == sis_pkg::ST_DRAIN);
  assign ctl.shl = take;
  assign ctl.up  = run_up_r;

  assign feed.vld = feed_vld_r;
  assign feed.key = feed_key_r;
  assign feed.tag = feed_tag_r;
  assign feed.pos = sis_pkg::POS_W'(feed_pos_r);

  // load buffer, arrival order
  always_ff @(posedge clk) begin
    if (in_acc && !full) begin
      store_mem[fill_r[AW-1:0]] <= in_tdata;
    end
    if (rd_en) begin
      feed_key_r <= store_mem[cnt_r[AW-1:0]][sis_pkg::KEY_W-1:0];
      feed_tag_r <= store_mem[cnt_r[AW-1:0]][sis_pkg::IN_DATA_W-1:sis_pkg::KEY_W];
    end
    feed_pos_r <= cnt_r[AW-1:0];
  end

  sis_chain #(.DEPTH(DEPTH)) u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .feed  (feed),
    .head  (head)
  );

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    cnt_nxt     = cnt_r;
    run_n_nxt   = run_n_r;
    ovf_nxt     = ovf_r;
    run_ovf_nxt = run_ovf_r;
    run_up_nxt  = run_up_r;
    unique case (state_r)
      sis_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            fill_nxt = fill_r + CW'(1);
          end
          if (in_tlast) begin
            run_n_nxt   = full ? fill_r : fill_r + CW'(1);
            run_ovf_nxt = ovf_r || full;
            run_up_nxt  = asc_r;
            fill_nxt    = '0;
            ovf_nxt     = 1'b0;
            cnt_nxt     = '0;
            state_nxt   = sis_pkg::ST_FEED;
          end
        end
      end
      sis_pkg::ST_FEED: begin
        cnt_nxt = cnt_r + CW'(1);
        if (run_done) begin
          cnt_nxt   = '0;
          state_nxt = sis_pkg::ST_DRAIN;
        end
      end
      sis_pkg::ST_DRAIN: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(DEPTH)) begin
          cnt_nxt   = '0;
          state_nxt = sis_pkg::ST_OUT;
        end
      end
      sis_pkg::ST_OUT: begin
        if (take) begin
          cnt_nxt = cnt_r + CW'(1);
          if (run_done) begin
            cnt_nxt   = '0;
            state_nxt = sis_pkg::ST_LOAD;
          end
        end
      end
      default: state_nxt = sis_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= sis_pkg::ST_LOAD;
      fill_r     <= '0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      asc_r      <= 1'b1;
      feed_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_r     <= fill_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      feed_vld_r <= rd_en;
      if (cfg_we) begin
        asc_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    run_n_r   <= run_n_nxt;
    run_ovf_r <= run_ovf_nxt;
    run_up_r  <= run_up_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (take) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {1'b0, run_ovf_r, head.pos, head.tag, head.key};
      out_last_r <= run_done;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/sis_chk.sv
module sis_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [sis_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  // loading resumes only once the final result of a run is on the output
  a_reopen_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> (out_tvalid && out_tlast))
    else $error("input reopened before final result was presented");

  // a closing item stops loading
  a_close_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input still open after closing item");

  // input closes only after a closing item
  a_close_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tlast))
    else $error("input closed without closing item");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled result changed");

endmodule

bind stable_insertion_sort sis_chk u_sis_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int ITEM_TARGET = 350;

  typedef struct {
    logic signed [sis_pkg::KEY_W-1:0] key;
    logic [sis_pkg::TAG_W-1:0]        tag;
    logic [sis_pkg::POS_W-1:0]        pos;
    logic                             ovf;
    logic                             fin;
  } sorted_entry_t;

  // keeps the run being loaded and the sorted results still owed by the block
  class sorted_run_board;
    sorted_entry_t held[$];
    sorted_entry_t sorted_due[$];
    bit            dropped = 1'b0;
    bit            up = 1'b1;
    int            errors = 0;

    function void set_direction(bit asc);
      up = asc;
    endfunction

    function int pending();
      return sorted_due.size();
    endfunction

    // stable insertion: an entry only passes those that must not stay ahead of it
    function void note_entry(logic signed [sis_pkg::KEY_W-1:0] k,
                             logic [sis_pkg::TAG_W-1:0] t, logic l);
      sorted_entry_t e;
      sorted_entry_t run[$];
      int slot;
      if (held.size() < DEPTH) begin
        e.key = k;
        e.tag = t;
        e.pos = sis_pkg::POS_W'(held.size());
        e.ovf = 1'b0;
        e.fin = 1'b0;
        held.push_back(e);
      end else begin
        dropped = 1'b1;
      end
      if (!l) return;
      foreach (held[j]) begin
        e = held[j];
        slot = run.size();
        while (slot > 0 && (up ? run[slot-1].key > e.key : run[slot-1].key < e.key))
          slot--;
        run.insert(slot, e);
      end
      foreach (run[j]) begin
        e = run[j];
        e.ovf = dropped;
        e.fin = (j == run.size() - 1);
        sorted_due.push_back(e);
      end
      held.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(logic [sis_pkg::OUT_DATA_W-1:0] d, logic l);
      sorted_entry_t e;
      if (sorted_due.size() == 0) begin
        $error("unexpected result: key %0d tag %0h", $signed(d[31:0]), d[47:32]);
        errors++;
        return;
      end
      e = sorted_due.pop_front();
      if (d[31:0] !== e.key) begin
        $error("out_key: expected %0d, got %0d", e.key, $signed(d[31:0]));
        errors++;
      end
      if (d[47:32] !== e.tag) begin
        $error("out_tag: expected %0h, got %0h", e.tag, d[47:32]);
        errors++;
      end
      if (d[53:48] !== e.pos) begin
        $error("origin_pos: expected %0d, got %0d", e.pos, d[53:48]);
        errors++;
      end
      if (d[54] !== e.ovf) begin
        $error("overflow: expected %0b, got %0b", e.ovf, d[54]);
        errors++;
      end
      if (l !== e.fin) begin
        $error("run_end: expected %0b, got %0b", e.fin, l);
        errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [sis_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // key, tag
  logic                           in_tlast = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [sis_pkg::OUT_DATA_W-1:0] out_tdata;  // out_key, out_tag, origin_pos, overflow
  logic                           out_tlast;
  logic                           cfg_we = 1'b0;
  logic                           cfg_wdata = 1'b0;

  sorted_run_board board = new;
  bit in_gaps = 1'b0;
  bit out_stalls = 1'b0;
  int hold_cnt = 0;
  int sent = 0;

  stable_insertion_sort #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      board.note_entry(in_tdata[31:0], in_tdata[47:32], in_tlast);
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata, out_tlast);
  end

  // receiver back-pressure in bursts of random length
  always @(posedge clk) begin
    if (!rst_n || !out_stalls) begin
      out_tready <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      hold_cnt <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // valid stays high after return; a random gap lowers it at the start of the next call, wait_drained before a pause
  task automatic send_item(input logic [31:0] k, input logic [15:0] t, input logic l);
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t, k};
    in_tlast <= l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_direction(input bit asc);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= asc;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_direction(asc);
  endtask

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    case ($urandom_range(0, 5))
      0: k = 32'($signed($urandom_range(0, 8)) - 4);
      1: begin
        case ($urandom_range(0, 3))
          0: k = 32'h8000_0000;
          1: k = 32'h7fff_ffff;
          2: k = 32'h0;
          default: k = 32'hffff_ffff;
        endcase
      end
      default: k = $urandom;
    endcase
    return k;
  endfunction

  task automatic load_run(input int len);
    for (int j = 0; j < len; j++)
      send_item(pick_key(), 16'($urandom_range(0, 65535)), j == len - 1);
  endtask

  initial begin
    int run_no;
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ascending from reset, extremes and equal keys
    send_item(32'h7fff_ffff, 16'h0000, 1'b0);
    send_item(32'h8000_0000, 16'hffff, 1'b0);
    send_item(32'h0000_0000, 16'h0001, 1'b0);
    send_item(32'hffff_ffff, 16'h0002, 1'b0);
    send_item(32'h0000_0003, 16'h0003, 1'b0);
    send_item(32'h0000_0003, 16'h0004, 1'b0);
    send_item(32'h8000_0000, 16'h0005, 1'b0);
    send_item(32'h7fff_ffff, 16'h0006, 1'b0);
    send_item(32'h0000_0001, 16'h0007, 1'b1);
    write_direction(1'b0);
    // descending keeps equal keys in arrival order too
    send_item(32'h0000_0005, 16'h0010, 1'b0);
    send_item(32'hffff_fffe, 16'h0011, 1'b0);
    send_item(32'h0000_0005, 16'h0012, 1'b0);
    send_item(32'h0000_0005, 16'h0013, 1'b0);
    send_item(32'h8000_0000, 16'h0014, 1'b0);
    send_item(32'h7fff_ffff, 16'h0015, 1'b0);
    send_item(32'hffff_fffe, 16'h0016, 1'b1);
    // single item run
    send_item(32'h1234_5678, 16'hffff, 1'b1);
    write_direction(1'b1);
    send_item(32'hdead_beef, 16'h00aa, 1'b0);
    send_item(32'hdead_beef, 16'h0055, 1'b1);

    run_no = 0;
    while (sent < ITEM_TARGET) begin
      if (sent > ITEM_TARGET - 60) begin
        in_gaps = 1'b0;
        out_stalls = 1'b0;
      end else begin
        in_gaps = $urandom_range(0, 3) != 0;
        out_stalls = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 2) == 0)
        write_direction(1'($urandom_range(0, 1)));
      // first a run that overflows, then one that fills the table exactly
      if (run_no == 0)
        len = DEPTH + 1;
      else if (run_no == 1)
        len = DEPTH;
      else if ($urandom_range(0, 11) == 0)
        len = $urandom_range(DEPTH, DEPTH + 6);
      else
        len = $urandom_range(1, 12);
      load_run(len);
      run_no++;
    end

    wait_drained();
    repeat (DEPTH + 10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
